// ===== hw/rtl/psd_pkg.sv =====
package psd_pkg;

    localparam int CW    = 24;
    localparam int TF    = 24;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int SW    = PW + 2;
    localparam int POSW  = TF + 1;
    localparam int DISTW = CW + 1;
    localparam int OFW   = POSW + 1 + DW;
    localparam int RW    = DW + 1;
    localparam int SQW   = 2 * RW + 2;
    localparam int SQRTW = SQW / 2;
    localparam int IN_BITS  = 9 * CW;
    localparam int IN_BYTES = (IN_BITS + 7) / 8;
    localparam int OUT_BITS  = DISTW + POSW;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [SW-1:0] wide_t;
    typedef logic [POSW-1:0] pos_t;
    typedef logic [1:0] region_t;
    typedef logic [SQW-1:0] sq_sum_t;

    localparam region_t REGION_INTERIOR = 2'd0;
    localparam region_t REGION_BEFORE   = 2'd1;
    localparam region_t REGION_PAST     = 2'd2;
    localparam region_t REGION_DEGEN    = 2'd3;

endpackage

// ===== hw/rtl/psd_front.sv =====
module psd_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  psd_pkg::coord_t      p [3],
    input  psd_pkg::coord_t      a [3],
    input  psd_pkg::coord_t      b [3],
    output logic                 out_valid,
    output psd_pkg::diff_t       v [3],
    output psd_pkg::diff_t       d [3],
    output psd_pkg::wide_t       dot,
    output psd_pkg::wide_t       len2
);

    logic                  vld1_reg, vld2_reg, vld3_reg;
    psd_pkg::diff_t        v1_reg [3];
    psd_pkg::diff_t        d1_reg [3];
    psd_pkg::diff_t        v2_reg [3];
    psd_pkg::diff_t        d2_reg [3];
    psd_pkg::diff_t        v3_reg [3];
    psd_pkg::diff_t        d3_reg [3];
    logic signed [psd_pkg::PW-1:0] pvd_reg [3];
    logic signed [psd_pkg::PW-1:0] pdd_reg [3];
    psd_pkg::wide_t        dot_reg, len2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v1_reg[i]  <= psd_pkg::diff_t'(p[i]) - psd_pkg::diff_t'(a[i]);
                d1_reg[i]  <= psd_pkg::diff_t'(b[i]) - psd_pkg::diff_t'(a[i]);
                pvd_reg[i] <= v1_reg[i] * d1_reg[i];
                pdd_reg[i] <= d1_reg[i] * d1_reg[i];
                v2_reg[i]  <= v1_reg[i];
                d2_reg[i]  <= d1_reg[i];
                v3_reg[i]  <= v2_reg[i];
                d3_reg[i]  <= d2_reg[i];
            end
            dot_reg  <= psd_pkg::wide_t'(pvd_reg[0]) + psd_pkg::wide_t'(pvd_reg[1])
                      + psd_pkg::wide_t'(pvd_reg[2]);
            len2_reg <= psd_pkg::wide_t'(pdd_reg[0]) + psd_pkg::wide_t'(pdd_reg[1])
                      + psd_pkg::wide_t'(pdd_reg[2]);
        end
    end

    assign out_valid = vld3_reg;
    assign v         = v3_reg;
    assign d         = d3_reg;
    assign dot       = dot_reg;
    assign len2      = len2_reg;

endmodule

// ===== hw/rtl/psd_div.sv =====
module psd_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  psd_pkg::diff_t       v_in [3],
    input  psd_pkg::diff_t       d_in [3],
    input  psd_pkg::wide_t       dot,
    input  psd_pkg::wide_t       len2,
    output logic                 out_valid,
    output psd_pkg::diff_t       v [3],
    output psd_pkg::diff_t       d [3],
    output psd_pkg::pos_t        t,
    output psd_pkg::region_t     region
);

    localparam int N = psd_pkg::TF;

    logic                       vld_reg  [N+1];
    logic [psd_pkg::SW-1:0]     rem_reg  [N+1];
    logic [psd_pkg::SW-1:0]     len2_reg [N+1];
    logic [N-1:0]               q_reg    [N+1];
    logic                       div_reg  [N+1];
    psd_pkg::pos_t              tfix_reg [N+1];
    psd_pkg::region_t           reg_reg  [N+1];
    psd_pkg::diff_t             v_reg    [N+1][3];
    psd_pkg::diff_t             d_reg    [N+1][3];

    psd_pkg::region_t           region_next;
    psd_pkg::pos_t              tfix_next;
    logic                       div_next;

    // classify the projection
    always_comb
    begin
        region_next = psd_pkg::REGION_INTERIOR;
        tfix_next   = '0;
        div_next    = 1'b0;
        if (len2 == '0)
        begin
            region_next = psd_pkg::REGION_DEGEN;
        end
        else if (dot < 0)
        begin
            region_next = psd_pkg::REGION_BEFORE;
        end
        else if (dot > len2)
        begin
            region_next = psd_pkg::REGION_PAST;
            tfix_next   = psd_pkg::pos_t'(1) << N;
        end
        else if (dot == len2)
        begin
            tfix_next = psd_pkg::pos_t'(1) << N;
        end
        else
        begin
            div_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 0; k < N; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= dot;
            len2_reg[0] <= len2;
            q_reg[0]    <= '0;
            div_reg[0]  <= div_next;
            tfix_reg[0] <= tfix_next;
            reg_reg[0]  <= region_next;
            v_reg[0]    <= v_in;
            d_reg[0]    <= d_in;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [psd_pkg::SW-1:0] shifted;
        logic                   fits;

        assign shifted = rem_reg[k] << 1;
        assign fits    = shifted >= len2_reg[k];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= fits ? shifted - len2_reg[k] : shifted;
                q_reg[k+1]    <= {q_reg[k][N-2:0], fits};
                len2_reg[k+1] <= len2_reg[k];
                div_reg[k+1]  <= div_reg[k];
                tfix_reg[k+1] <= tfix_reg[k];
                reg_reg[k+1]  <= reg_reg[k];
                v_reg[k+1]    <= v_reg[k];
                d_reg[k+1]    <= d_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign v         = v_reg[N];
    assign d         = d_reg[N];
    assign t         = div_reg[N] ? {1'b0, q_reg[N]} : tfix_reg[N];
    assign region    = reg_reg[N];

endmodule

// ===== hw/rtl/psd_resid.sv =====
module psd_resid
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  psd_pkg::diff_t       v [3],
    input  psd_pkg::diff_t       d [3],
    input  psd_pkg::pos_t        t_in,
    input  psd_pkg::region_t     region_in,
    output logic                 out_valid,
    output psd_pkg::sq_sum_t     sum,
    output psd_pkg::pos_t        t,
    output psd_pkg::region_t     region
);

    localparam int OFW = psd_pkg::OFW;
    localparam int RW  = psd_pkg::RW;

    logic                    vld_reg [4];
    psd_pkg::pos_t           t_reg   [4];
    psd_pkg::region_t        rg_reg  [4];
    psd_pkg::diff_t          v1_reg  [3];
    logic signed [OFW-1:0]   prod_reg [3];
    logic signed [RW-1:0]    res_reg  [3];
    logic signed [2*RW-1:0]  sq_reg   [3];
    psd_pkg::sq_sum_t        sum_reg;
    logic signed [OFW-1:0]   off    [3];
    logic signed [OFW-1:0]   rfull  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            off[i]   = prod_reg[i] >>> psd_pkg::TF;
            rfull[i] = OFW'(v1_reg[i]) - off[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 0; k < 3; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]  <= t_in;
            rg_reg[0] <= region_in;
            for (int k = 0; k < 3; k++)
            begin
                t_reg[k+1]  <= t_reg[k];
                rg_reg[k+1] <= rg_reg[k];
            end
            for (int i = 0; i < 3; i++)
            begin
                v1_reg[i]   <= v[i];
                prod_reg[i] <= $signed({2'b00, t_in}) * OFW'(d[i]);
                res_reg[i]  <= rfull[i][RW-1:0];
                sq_reg[i]   <= res_reg[i] * res_reg[i];
            end
            sum_reg <= psd_pkg::sq_sum_t'($unsigned(sq_reg[0]))
                     + psd_pkg::sq_sum_t'($unsigned(sq_reg[1]))
                     + psd_pkg::sq_sum_t'($unsigned(sq_reg[2]));
        end
    end

    assign out_valid = vld_reg[3];
    assign sum       = sum_reg;
    assign t         = t_reg[3];
    assign region    = rg_reg[3];

endmodule

// ===== hw/rtl/psd_sqrt.sv =====
module psd_sqrt
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  psd_pkg::sq_sum_t     sum,
    input  psd_pkg::pos_t        t_in,
    input  psd_pkg::region_t     region_in,
    output logic                 out_valid,
    output logic [psd_pkg::DISTW-1:0] distance,
    output psd_pkg::pos_t        t,
    output psd_pkg::region_t     region
);

    localparam int N   = psd_pkg::SQRTW;
    localparam int SQW = psd_pkg::SQW;

    logic                vld_reg  [N+1];
    logic [SQW-1:0]      rad_reg  [N+1];
    logic [N+1:0]        rem_reg  [N+1];
    logic [N-1:0]        root_reg [N+1];
    psd_pkg::pos_t       t_reg    [N+1];
    psd_pkg::region_t    rg_reg   [N+1];

    always_comb
    begin
        vld_reg[0]  = in_valid;
        rad_reg[0]  = sum;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        t_reg[0]    = t_in;
        rg_reg[0]   = region_in;
    end

    // two radicand bits per stage
    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [N+1:0] rem_sh;
        logic [N+1:0] trial;
        logic         fits;

        assign rem_sh = {rem_reg[k][N-1:0], rad_reg[k][SQW-1 -: 2]};
        assign trial  = {root_reg[k], 2'b01};
        assign fits   = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k+1]  <= rad_reg[k] << 2;
                rem_reg[k+1]  <= fits ? rem_sh - trial : rem_sh;
                root_reg[k+1] <= {root_reg[k][N-2:0], fits};
                t_reg[k+1]    <= t_reg[k];
                rg_reg[k+1]   <= rg_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign distance  = root_reg[N][psd_pkg::DISTW-1:0];
    assign t         = t_reg[N];
    assign region    = rg_reg[N];

endmodule

// ===== hw/rtl/point_segment_distance.sv =====
// Distance from a 3D point to a segment, all coordinates signed with 8 fraction bits.
// One beat per cycle in and out while the output is not held. The stages are differences,
// products and sums, then classification, then the restoring divider that gives one bit
// of the projection t per stage, then offset, residual, squares and sum, and then the 27
// square root stages, one result bit each. When the output is held the whole
// pipeline stops in place.
module point_segment_distance
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // px, py, pz, ax, ay, az, bx, by, bz
    input  logic [psd_pkg::IN_BYTES*8-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // distance, position, zero padding
    output logic [psd_pkg::OUT_BYTES*8-1:0]   m_tdata,
    // region
    output logic [1:0]                        m_tuser
);

    localparam int CW = psd_pkg::CW;

    logic                 en;
    psd_pkg::coord_t      p [3];
    psd_pkg::coord_t      a [3];
    psd_pkg::coord_t      b [3];

    logic                 f_valid;
    psd_pkg::diff_t       f_v [3];
    psd_pkg::diff_t       f_d [3];
    psd_pkg::wide_t       f_dot, f_len2;

    logic                 q_valid;
    psd_pkg::diff_t       q_v [3];
    psd_pkg::diff_t       q_d [3];
    psd_pkg::pos_t        q_t;
    psd_pkg::region_t     q_region;

    logic                 r_valid;
    psd_pkg::sq_sum_t     r_sum;
    psd_pkg::pos_t        r_t;
    psd_pkg::region_t     r_region;

    logic                 o_valid;
    logic [psd_pkg::DISTW-1:0] o_dist;
    psd_pkg::pos_t        o_t;
    psd_pkg::region_t     o_region;

    assign en       = !o_valid || m_tready;
    assign s_tready = en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p[i] = s_tdata[i*CW +: CW];
            a[i] = s_tdata[(3+i)*CW +: CW];
            b[i] = s_tdata[(6+i)*CW +: CW];
        end
    end

    psd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .p         (p),
        .a         (a),
        .b         (b),
        .out_valid (f_valid),
        .v         (f_v),
        .d         (f_d),
        .dot       (f_dot),
        .len2      (f_len2)
    );

    psd_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .v_in      (f_v),
        .d_in      (f_d),
        .dot       (f_dot),
        .len2      (f_len2),
        .out_valid (q_valid),
        .v         (q_v),
        .d         (q_d),
        .t         (q_t),
        .region    (q_region)
    );

    psd_resid u_resid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .v         (q_v),
        .d         (q_d),
        .t_in      (q_t),
        .region_in (q_region),
        .out_valid (r_valid),
        .sum       (r_sum),
        .t         (r_t),
        .region    (r_region)
    );

    psd_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .sum       (r_sum),
        .t_in      (r_t),
        .region_in (r_region),
        .out_valid (o_valid),
        .distance  (o_dist),
        .t         (o_t),
        .region    (o_region)
    );

    assign m_tvalid = o_valid;
    assign m_tdata  = {{(psd_pkg::OUT_BYTES*8 - psd_pkg::OUT_BITS){1'b0}}, o_t, o_dist};
    assign m_tuser  = o_region;

endmodule

// ===== tb/psd_checker.sv =====
module psd_checker
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    input  logic                                      s_tready,
    input  logic [psd_pkg::IN_BYTES*8-1:0]            s_tdata,
    input  logic                                      m_tvalid,
    input  logic                                      m_tready,
    input  logic [psd_pkg::OUT_BYTES*8-1:0]           m_tdata,
    input  logic [1:0]                                m_tuser,
    output int                                        errors,
    output int                                        pending,
    output int                                        beats_in,
    output int                                        beats_out,
    output int                                        region_seen [4]
);

    typedef struct packed {
        logic [psd_pkg::DISTW-1:0] distance;
        psd_pkg::pos_t             position;
        psd_pkg::region_t          region;
    } answer_t;

    answer_t answers_due[$];

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic answer_t nearest_distance(logic [psd_pkg::IN_BITS-1:0] q);
        answer_t ans;
        longint v [3];
        longint d [3];
        longint unsigned len2;
        longint dot;
        longint unsigned t;
        longint unsigned rem;
        longint unsigned sum;
        longint res;
        psd_pkg::coord_t p, a, b;
        psd_pkg::region_t zone;
        len2 = 0;
        dot = 0;
        t = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            p = q[i*psd_pkg::CW +: psd_pkg::CW];
            a = q[(3+i)*psd_pkg::CW +: psd_pkg::CW];
            b = q[(6+i)*psd_pkg::CW +: psd_pkg::CW];
            v[i] = longint'(p) - longint'(a);
            d[i] = longint'(b) - longint'(a);
            len2 += d[i] * d[i];
            dot += v[i] * d[i];
        end
        if (len2 == 0)
            zone = psd_pkg::REGION_DEGEN;
        else if (dot < 0)
            zone = psd_pkg::REGION_BEFORE;
        else if ($unsigned(dot) > len2)
        begin
            zone = psd_pkg::REGION_PAST;
            t = 64'd1 << psd_pkg::TF;
        end
        else if ($unsigned(dot) == len2)
        begin
            zone = psd_pkg::REGION_INTERIOR;
            t = 64'd1 << psd_pkg::TF;
        end
        else
        begin
            zone = psd_pkg::REGION_INTERIOR;
            rem = dot;
            for (int k = 0; k < psd_pkg::TF; k++)
            begin
                rem <<= 1;
                t <<= 1;
                if (rem >= len2)
                begin
                    rem -= len2;
                    t |= 1;
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            res = v[i] - floor_shift(longint'(t) * d[i], psd_pkg::TF);
            sum += res * res;
        end
        ans.distance = psd_pkg::DISTW'(root_floor(sum));
        ans.position = psd_pkg::POSW'(t);
        ans.region = zone;
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            errors <= 0;
            pending <= 0;
            beats_in <= 0;
            beats_out <= 0;
            for (int i = 0; i < 4; i++)
                region_seen[i] <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                answers_due.insert(answers_due.size(),
                                   nearest_distance(s_tdata[psd_pkg::IN_BITS-1:0]));
                beats_in <= beats_in + 1;
            end
            if (m_tvalid && m_tready)
            begin
                beats_out <= beats_out + 1;
                got.distance = m_tdata[psd_pkg::DISTW-1:0];
                got.position = m_tdata[psd_pkg::DISTW +: psd_pkg::POSW];
                got.region = m_tuser;
                region_seen[got.region] <= region_seen[got.region] + 1;
                if (answers_due.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected output beat: dist %0d pos %0d region %0d",
                                 got.distance, got.position, got.region);
                    errors <= errors + 1;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got !== want)
                    begin
                        if (errors < 10)
                            $display("mismatch: exp dist %0d pos %0d region %0d, got %0d %0d %0d",
                                     want.distance, want.position, want.region,
                                     got.distance, got.position, got.region);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= answers_due.size();
        end
    end
endmodule

// ===== tb/tb_point_segment_distance.sv =====
module tb_point_segment_distance;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    logic [psd_pkg::IN_BYTES*8-1:0]       s_tdata = '0;
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [psd_pkg::OUT_BYTES*8-1:0]      m_tdata;
    logic [1:0]                           m_tuser;
    int errors, pending, beats_in, beats_out;
    int region_seen [4];
    int idle_left = 0;
    bit calm = 1'b0;
    bit hold_off = 1'b0;

    localparam int NUM_RANDOM = 1000;

    always #4 clk = ~clk;

    point_segment_distance dut (.*);

    psd_checker checker_i (.*);

    function automatic psd_pkg::coord_t any_coord();
        case ($urandom_range(0, 5))
            0: return psd_pkg::coord_t'(32'h0080_0000);
            1: return psd_pkg::coord_t'(32'h007f_ffff);
            2: return psd_pkg::coord_t'($urandom_range(0, 1023) - 512);
            default: return psd_pkg::coord_t'($urandom);
        endcase
    endfunction

    task automatic send(input psd_pkg::coord_t c [9]);
        s_tvalid <= 1'b1;
        for (int i = 0; i < 9; i++)
            s_tdata[i*psd_pkg::CW +: psd_pkg::CW] <= c[i];
        @(posedge clk iff s_tready);
        @(negedge clk);
    endtask

    task automatic send_random(input int kind);
        psd_pkg::coord_t c [9];
        int span;
        span = $urandom_range(0, 3) == 0 ? 23 : $urandom_range(4, 14);
        for (int i = 0; i < 9; i++)
            c[i] = kind == 0 ? any_coord()
                             : psd_pkg::coord_t'($signed($urandom) >>> (31 - span));
        if (kind == 2)
            for (int i = 0; i < 3; i++)
                c[6+i] = c[3+i];
        if (kind == 3)
            for (int i = 0; i < 3; i++)
                c[i] = c[3 + 3 * $urandom_range(0, 1) + i];
        send(c);
    endtask

    task automatic gap();
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            m_tready <= 1'b0;
        else if (calm)
            m_tready <= 1'b1;
        else if (idle_left > 0)
        begin
            idle_left <= idle_left - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            idle_left <= $urandom_range(0, 17);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        psd_pkg::coord_t c [9];
        int directed [13][9] = '{
            '{0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{256, 256, 0, 0, 0, 0, 0, 0, 0},
            '{128, 300, 0, 0, 0, 0, 256, 0, 0},
            '{-256, 5, 0, 0, 0, 0, 256, 0, 0},
            '{900, 5, 0, 0, 0, 0, 256, 0, 0},
            '{0, 77, 9, 0, 0, 0, 256, 0, 0},
            '{256, 77, 9, 0, 0, 0, 256, 0, 0},
            '{-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
              -8388608, -8388608, -8388608},
            '{8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
              -8388608, 8388607, -8388608},
            '{8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
              -8388608, -8388608, -8388608},
            '{-1, -1, -1, 1, 1, 1, 1, 1, 1},
            '{1000, -7000, 300, -5, 3, 7, 200, -900, 4000},
            '{8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
              8388607, 8388607, 8388607}
        };
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[n])
        begin
            foreach (c[i])
                c[i] = psd_pkg::coord_t'(directed[n][i]);
            send(c);
            gap();
        end
        // stall the output so the pipeline fills and backs up the input
        hold_off = 1'b1;
        fork
            begin
                for (int n = 0; n < 80; n++)
                    send_random(1);
            end
            begin
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
        join
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == NUM_RANDOM - 150)
                calm = 1'b1;
            send_random($urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 3) == 1
                        ? 1 : $urandom_range(0, 9) < 7 ? 1 : $urandom_range(2, 3));
            gap();
        end
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (80) @(negedge clk);
        $display("%0d queries in, %0d results out", beats_in, beats_out);
        $display("regions interior/before/past/zero-length: %0d/%0d/%0d/%0d",
                 region_seen[0], region_seen[1], region_seen[2], region_seen[3]);
        if (errors == 0)
            $display("[point_segment_distance] OK");
        else
            $display("[point_segment_distance] ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("[point_segment_distance] ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/psd_pkg.sv
hw/rtl/psd_front.sv
hw/rtl/psd_div.sv
hw/rtl/psd_resid.sv
hw/rtl/psd_sqrt.sv
hw/rtl/point_segment_distance.sv
tb/psd_checker.sv
tb/tb_point_segment_distance.sv
